FILE: hw/rtl/sktab_pkg.sv
// ----------------------------------------------------------------------------
// sktab_pkg: shared types and codes for the sorted key table
// Command and status codes, the key width and the control word that the
// top level hands to every cell of the key chain.
// ----------------------------------------------------------------------------
package sktab_pkg;

    // Width of one stored key.
    localparam int KEY_W = 32;

    // Command codes; the unused code behaves as a lookup.
    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    // Status codes returned with every result word.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;

    // Control word broadcast to the cells.
    typedef struct packed {
        logic capture;  // compare the incoming key against every held key
        logic insert;   // open a gap at the insertion point and write the key
        logic remove;   // close the gap at the matching key
    } sktab_ctrl_t;

endpackage

FILE: hw/rtl/sktab_cell.sv
// ----------------------------------------------------------------------------
// sktab_cell: one slot of the sorted key chain
// Holds one key, compares it against the incoming key and takes a key from
// its left or right neighbor when the chain opens or closes a gap.
// ----------------------------------------------------------------------------
module sktab_cell #(
    parameter int CELL_INDEX = 0,
    parameter int CNT_W      = 9
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  sktab_pkg::sktab_ctrl_t    ctrl,
    input  logic [CNT_W-1:0]          count,
    input  logic [sktab_pkg::KEY_W-1:0] probe_key,
    input  logic [sktab_pkg::KEY_W-1:0] new_key,
    input  logic [sktab_pkg::KEY_W-1:0] left_key,
    input  logic [sktab_pkg::KEY_W-1:0] right_key,
    input  logic                      left_lt,
    output logic [sktab_pkg::KEY_W-1:0] key_out,
    output logic                      lt_out,
    output logic                      eq_out,
    output logic                      at_pos
);

    logic [sktab_pkg::KEY_W-1:0] key_reg;
    logic [sktab_pkg::KEY_W-1:0] key_next;
    logic                        lt_reg;
    logic                        lt_next;
    logic                        eq_reg;
    logic                        eq_next;
    logic                        occupied;

    // A slot holds a live key only below the fill count.
    assign occupied = (CNT_W'(CELL_INDEX) < count);

    // Compare flags are taken when a word is accepted and held for the update.
    always_comb
    begin
        lt_next = lt_reg;
        eq_next = eq_reg;
        if (ctrl.capture)
        begin
            lt_next = occupied && (key_reg < probe_key);
            eq_next = occupied && (key_reg == probe_key);
        end
    end

    // This slot is the insertion point when its left neighbor is smaller
    // and it is not.
    assign at_pos = left_lt && !lt_reg;

    // Slots at or above the insertion point move right on insert and left
    // on remove; smaller keys stay where they are.
    always_comb
    begin
        key_next = key_reg;
        if (ctrl.insert && !lt_reg)
        begin
            key_next = at_pos ? new_key : left_key;
        end
        else if (ctrl.remove && !lt_reg)
        begin
            key_next = right_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else
        begin
            lt_reg <= lt_next;
            eq_reg <= eq_next;
        end
    end

    // Key storage is undefined until written.
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key_out = key_reg;
    assign lt_out  = lt_reg;
    assign eq_out  = eq_reg;

endmodule

FILE: hw/rtl/sktab_locate.sv
// ----------------------------------------------------------------------------
// sktab_locate: turns the chain's compare flags into a position
// Encodes the one-hot insertion point into an index and reduces the
// per-slot match flags into a single hit.
// ----------------------------------------------------------------------------
module sktab_locate #(
    parameter int DEPTH = 256,
    parameter int CNT_W = 9
) (
    input  logic [DEPTH-1:0] at_pos_vec,
    input  logic [DEPTH-1:0] eq_vec,
    input  logic             all_lt,
    output logic [CNT_W-1:0] pos,
    output logic             hit
);

    logic [CNT_W-1:0] pos_or;

    // At most one slot flags the insertion point, so an OR of the flagged
    // indices is its index.
    always_comb
    begin
        pos_or = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            pos_or = pos_or | ({CNT_W{at_pos_vec[i]}} & CNT_W'(i));
        end
    end

    // When every slot is smaller the key belongs past the last slot.
    assign pos = all_lt ? CNT_W'(DEPTH) : pos_or;

    // Only the slot at the insertion point can match a unique key.
    assign hit = |eq_vec;

endmodule

FILE: hw/rtl/sorted_key_table.sv
// ----------------------------------------------------------------------------
// sorted_key_table: ordered table of unique keys
// A chain of key cells compares every held key against the incoming key in
// parallel and shifts to insert or remove in place.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake      | Words
//  ---------+----------------+--------------------------------------------
//  command  | start / busy   | cmd, key, hint_position
//  result   | done (strobe)  | found, position, status, entry_count
//
//  Every command runs in two steps: the accept edge registers the compare of
//  all slots at once, the next edge updates the chain and the fill count
//  and presents the result word. busy is high only in that update cycle,
//  so a new command can start in the cycle the result is shown.
//  Reset empties the table at once (the fill count goes to zero); no
//  clearing pass is needed. The result receiver cannot stall.
//  hint_position is accepted but does not matter: every slot is probed.
//
module sorted_key_table #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          cmd,
    input  logic [sktab_pkg::KEY_W-1:0]         key,
    input  logic [7:0]                          hint_position,
    output logic                                done,
    output logic                                found,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]    position,
    output logic [1:0]                          status,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]    entry_count
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic                        accept;
    logic                        busy_reg;
    logic                        busy_next;
    logic                        done_reg;
    logic                        done_next;
    logic [1:0]                  cmd_reg;
    logic [sktab_pkg::KEY_W-1:0] item_key_reg;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic                        found_reg;
    logic [CNT_W-1:0]            position_reg;
    logic [1:0]                  status_reg;
    logic [1:0]                  status_next;
    sktab_pkg::sktab_ctrl_t      ctrl;
    logic                        table_full;
    logic                        do_insert;
    logic                        do_remove;
    logic [CNT_W-1:0]            loc_pos;
    logic                        loc_hit;

    logic [sktab_pkg::KEY_W-1:0] key_vec [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]      lt_vec;
    logic [TABLE_DEPTH-1:0]      eq_vec;
    logic [TABLE_DEPTH-1:0]      at_pos_vec;

    // A command is taken whenever the chain is not in its update cycle.
    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    // Decide the update from the located position and the command.
    assign table_full = (count_reg == CNT_W'(TABLE_DEPTH));
    assign do_insert  = busy_reg && (cmd_reg == sktab_pkg::CMD_INSERT) &&
                        !loc_hit && !table_full;
    assign do_remove  = busy_reg && (cmd_reg == sktab_pkg::CMD_REMOVE) && loc_hit;

    assign ctrl.capture = accept;
    assign ctrl.insert  = do_insert;
    assign ctrl.remove  = do_remove;

    // Fill count and status for the result word.
    always_comb
    begin
        count_next  = count_reg;
        status_next = sktab_pkg::ST_OK;
        if (do_insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_remove)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        if ((cmd_reg == sktab_pkg::CMD_INSERT) && !loc_hit && table_full)
        begin
            status_next = sktab_pkg::ST_FULL;
        end
        else if ((cmd_reg == sktab_pkg::CMD_REMOVE) && !loc_hit)
        begin
            status_next = sktab_pkg::ST_ABSENT;
        end
    end

    assign busy_next = accept;
    assign done_next = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // Command latch and result word registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg      <= cmd;
            item_key_reg <= key;
        end
        if (busy_reg)
        begin
            found_reg    <= loc_hit;
            position_reg <= loc_pos;
            status_reg   <= status_next;
        end
    end

    // The key chain; the ends see a smaller left neighbor and their own key.
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        logic [sktab_pkg::KEY_W-1:0] left_key;
        logic [sktab_pkg::KEY_W-1:0] right_key;
        logic                        left_lt;

        if (i == 0)
        begin : g_first
            assign left_key = item_key_reg;
            assign left_lt  = 1'b1;
        end
        else
        begin : g_mid
            assign left_key = key_vec[i-1];
            assign left_lt  = lt_vec[i-1];
        end

        if (i == TABLE_DEPTH - 1)
        begin : g_last
            assign right_key = key_vec[i];
        end
        else
        begin : g_inner
            assign right_key = key_vec[i+1];
        end

        sktab_cell #(
            .CELL_INDEX (i),
            .CNT_W      (CNT_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .count     (count_reg),
            .probe_key (key),
            .new_key   (item_key_reg),
            .left_key  (left_key),
            .right_key (right_key),
            .left_lt   (left_lt),
            .key_out   (key_vec[i]),
            .lt_out    (lt_vec[i]),
            .eq_out    (eq_vec[i]),
            .at_pos    (at_pos_vec[i])
        );
    end

    sktab_locate #(
        .DEPTH (TABLE_DEPTH),
        .CNT_W (CNT_W)
    ) u_locate (
        .at_pos_vec (at_pos_vec),
        .eq_vec     (eq_vec),
        .all_lt     (lt_vec[TABLE_DEPTH-1]),
        .pos        (loc_pos),
        .hit        (loc_hit)
    );

    assign done        = done_reg;
    assign found       = found_reg;
    assign position    = position_reg;
    assign status      = status_reg;
    assign entry_count = count_reg;

endmodule

FILE: hw/rtl/sktab_checker.sv
// ----------------------------------------------------------------------------
// sktab_checker: port-level checks for the sorted key table
// Watches the command and result ports over time and is bound to the top
// level.
// ----------------------------------------------------------------------------
module sktab_checker #(
    parameter int TABLE_DEPTH = 256
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             start,
    input logic                             busy,
    input logic                             done,
    input logic                             found,
    input logic [$clog2(TABLE_DEPTH+1)-1:0] position,
    input logic [1:0]                       status,
    input logic [$clog2(TABLE_DEPTH+1)-1:0] entry_count
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // An accepted command occupies exactly one update cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_busy_once: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (!busy && done))
        else $error("update cycle did not end with a result word");

    // A result word only follows an update cycle.
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result word without a command");

    // A refused insert leaves a full table and reports no hit.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == sktab_pkg::ST_FULL) |->
            (!found && entry_count == CNT_W'(TABLE_DEPTH)))
        else $error("full status with a table that is not full");

    // A found key lies inside the table that held it.
    a_found_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (done && found) |-> (position < CNT_W'(TABLE_DEPTH)))
        else $error("hit reported past the last slot");

endmodule

bind sorted_key_table sktab_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_sktab_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .found       (found),
    .position    (position),
    .status      (status),
    .entry_count (entry_count)
);
